@@ hw/rtl/ptc_pkg.sv @@
//------------------------------------------------------------------------------
// ptc_pkg: shared types and constants for the PI turn controller
// Holds the payload structs, the register indexes and the reset values.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptc_pkg;

  // Error sum, operand and field widths, and derived product widths
  localparam int SUM_W    = 24;
  localparam int HEAD_W   = 16;
  localparam int GAIN_W   = 10;
  localparam int FRAC_W   = 8;
  localparam int PPROD_W  = GAIN_W + HEAD_W;
  localparam int P_W      = PPROD_W - FRAC_W;
  localparam int BIAS_W   = SUM_W + 1;
  localparam int IPROD_W  = GAIN_W + BIAS_W;
  localparam int I_W      = IPROD_W - FRAC_W;
  localparam int LIM_W    = 7;
  localparam int PWR_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM    = 3'd5;

  // Register reset values
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 10'd179;
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 10'd10;
  localparam logic [7:0]        RST_GATE       = 8'd32;
  localparam logic [9:0]        RST_BIAS       = 10'd100;
  localparam logic [LIM_W-1:0]  RST_INTEG_LIM  = 7'd40;
  localparam logic [LIM_W-1:0]  RST_OUT_LIM    = 7'd84;

  // Input actions
  localparam logic ACT_BEGIN  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic                     action;
    logic signed [HEAD_W-1:0] heading;
    logic signed [HEAD_W-1:0] target;
  } ptc_in_t;

  typedef struct packed {
    logic signed [PWR_W-1:0] left_power;
    logic signed [PWR_W-1:0] right_power;
    logic                    done_res;
  } ptc_out_t;

endpackage

@@ hw/rtl/pi_turn_controller_gated_integral.sv @@
//------------------------------------------------------------------------------
// pi_turn_controller_gated_integral: PI heading controller for a turn
// Latches a goal on begin, then turns P + gated, clamped I into opposite
// side drive commands until the heading reaches or crosses the goal.
//------------------------------------------------------------------------------
// Path: input register, then one compute pass into the result register.
// Throughput: one item per cycle unless out_stall blocks the result register;
//   the single compute pass sets the rate.
// Reset (rst_n low, synchronous): pipeline emptied, move idle, error sum and
//   goal cleared, configuration back to its default values.
`timescale 1ns / 1ps

module pi_turn_controller_gated_integral (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ptc_pkg::ptc_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ptc_pkg::ptc_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ptc_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0] prop_gain_r;
  logic [GAIN_W-1:0] integ_gain_r;
  logic [7:0]        gate_r;
  logic [9:0]        bias_r;
  logic [LIM_W-1:0]  integ_lim_r;
  logic [LIM_W-1:0]  out_lim_r;

  // Pipeline and move state
  ptc_in_t                  s1_r;
  logic                     s1_valid_r;
  ptc_out_t                 out_r;
  logic                     out_valid_r;
  logic                     active_r,   active_nxt;
  logic                     turn_neg_r, turn_neg_nxt;
  logic signed [HEAD_W-1:0] goal_r,     goal_nxt;
  logic [SUM_W-1:0]         sum_r,      sum_nxt;
  ptc_out_t                 res_nxt;

  logic out_free;
  logic s1_adv;
  logic in_xfer;

  // Handshake: result register frees on transfer, input stage drains into it
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Datapath intermediates
  logic signed [HEAD_W:0]   diff;
  logic [HEAD_W-1:0]        err;
  logic                     going;
  logic [PPROD_W-1:0]       p_prod;
  logic [P_W-1:0]           p_val;
  logic [SUM_W:0]           sum_add;
  logic [SUM_W-1:0]         sum_sat;
  logic [BIAS_W-1:0]        biased;
  logic [IPROD_W-1:0]       i_prod;
  logic [I_W-1:0]           i_full;
  logic [LIM_W-1:0]         i_val;
  logic                     gated;
  logic [P_W:0]             pw_sum;
  logic [LIM_W-1:0]         pw;
  logic signed [PWR_W-1:0]  pw_pos;
  logic signed [PWR_W-1:0]  pw_neg;

  // Compute the control step from the input register and the move state
  always_comb begin
    diff    = turn_neg_r ? ({s1_r.heading[HEAD_W-1], s1_r.heading} -
                            {goal_r[HEAD_W-1], goal_r})
                         : ({goal_r[HEAD_W-1], goal_r} -
                            {s1_r.heading[HEAD_W-1], s1_r.heading});
    err     = diff[HEAD_W-1:0];
    going   = turn_neg_r ? (s1_r.heading > goal_r) : (s1_r.heading < goal_r);
    p_prod  = PPROD_W'(prop_gain_r) * PPROD_W'(err);
    p_val   = p_prod[PPROD_W-1:FRAC_W];
    gated   = p_val > P_W'(gate_r);
    sum_add = {1'b0, sum_r} + (SUM_W+1)'(err);
    sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    biased  = {1'b0, sum_sat} + BIAS_W'(bias_r);
    i_prod  = IPROD_W'(integ_gain_r) * IPROD_W'(biased);
    i_full  = i_prod[IPROD_W-1:FRAC_W];
    i_val   = (i_full > I_W'(integ_lim_r)) ? integ_lim_r : i_full[LIM_W-1:0];
    pw_sum  = {1'b0, p_val} + (P_W+1)'(gated ? '0 : i_val);
    pw      = (pw_sum > (P_W+1)'(out_lim_r)) ? out_lim_r : pw_sum[LIM_W-1:0];
    pw_pos  = $signed({1'b0, pw});
    pw_neg  = -pw_pos;

    active_nxt   = active_r;
    turn_neg_nxt = turn_neg_r;
    goal_nxt     = goal_r;
    sum_nxt      = sum_r;
    res_nxt      = '0;

    if (s1_r.action == ACT_BEGIN) begin
      goal_nxt = s1_r.target;
      sum_nxt  = '0;
      if (s1_r.target == s1_r.heading) begin
        active_nxt       = 1'b0;
        res_nxt.done_res = 1'b1;
      end else begin
        active_nxt   = 1'b1;
        turn_neg_nxt = s1_r.target < s1_r.heading;
      end
    end else if (active_r) begin
      if (!going) begin
        active_nxt       = 1'b0;
        res_nxt.done_res = 1'b1;
      end else begin
        sum_nxt             = gated ? '0 : sum_sat;
        res_nxt.left_power  = turn_neg_r ? pw_neg : pw_pos;
        res_nxt.right_power = turn_neg_r ? pw_pos : pw_neg;
      end
    end
  end

  // Hold configuration, pipeline and move state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= RST_PROP_GAIN;
      integ_gain_r <= RST_INTEG_GAIN;
      gate_r       <= RST_GATE;
      bias_r       <= RST_BIAS;
      integ_lim_r  <= RST_INTEG_LIM;
      out_lim_r    <= RST_OUT_LIM;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      active_r     <= 1'b0;
      turn_neg_r   <= 1'b0;
      goal_r       <= '0;
      sum_r        <= '0;
    end else begin
      // Apply a configuration write
      if (cfg_we) begin
        case (cfg_idx)
          REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
          REG_INTEG_GAIN: integ_gain_r <= cfg_wdata;
          REG_GATE:       gate_r       <= cfg_wdata[7:0];
          REG_BIAS:       bias_r       <= cfg_wdata;
          REG_INTEG_LIM:  integ_lim_r  <= cfg_wdata[LIM_W-1:0];
          REG_OUT_LIM:    out_lim_r    <= cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end

      // Advance the input stage
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      // Commit the step and load the result register
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        active_r    <= active_nxt;
        turn_neg_r  <= turn_neg_nxt;
        goal_r      <= goal_nxt;
        sum_r       <= sum_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= res_nxt;
    end
  end

  // A valid result drives the two sides in opposite directions
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.left_power == -out_r.right_power))
    else $error("left and right power not opposite");

  // A finishing result carries no drive
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res) |-> (out_r.left_power == '0))
    else $error("done result with nonzero power");

  // Drive stays inside the output clamp
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_r.right_power <= $signed({1'b0, out_lim_r}) &&
                out_r.right_power >= -$signed({1'b0, out_lim_r})))
    else $error("power beyond output limit");

  // A committed step always produces a valid result
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("committed step lost");

  // The input side only stalls behind a blocked result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_valid_r))
    else $error("input stalled without backpressure");

endmodule

@@ bench/pi_turn_controller_gated_integral_tb.sv @@
//------------------------------------------------------------------------------
// pi_turn_controller_gated_integral_tb: self-checking bench for the turn PI
// Drives begin and sample transfers through the valid/stall channel and
// predicts each result with a local model of the controller. The run starts
// with a short directed table, then goes through several register settings
// with random moves that converge on their goal. It also includes a long
// far-off move that drives the error sum into saturation. Random idle bursts
// hit both channels except in the final phase.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module pi_turn_controller_gated_integral_tb;
  import ptc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 225;
  localparam int SAT_RUN     = 256;
  localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 64'd1;

  typedef struct {
    ptc_in_t  item;
    bit       known;
    ptc_out_t result;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  ptc_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  ptc_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Register copies and controller state of the predictor
  logic [GAIN_W-1:0] kp_q8;
  logic [GAIN_W-1:0] ki_q8;
  logic [7:0]        gate_lvl;
  logic [9:0]        bias_val;
  logic [LIM_W-1:0]  ilim;
  logic [LIM_W-1:0]  olim;
  bit                move_on;
  bit                turn_neg;
  int                goal_hd;
  longint unsigned   err_sum;

  ptc_out_t expected_turns[$];
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  int       items_sent = 0;
  int       cycle_cnt  = 0;
  bit       quiet      = 1'b0;
  bit       gappy      = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pi_turn_controller_gated_integral i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Work out the drive command for one transfer and advance the move state
  function automatic ptc_out_t predict_turn(input ptc_in_t it);
    ptc_out_t          r;
    int                hd;
    int                tg;
    bit                going;
    longint unsigned   errv;
    longint unsigned   p;
    longint unsigned   itg;
    longint unsigned   pw;
    logic [PWR_W-1:0]  pw8;
    r  = '0;
    hd = $signed(it.heading);
    tg = $signed(it.target);
    if (it.action == ACT_BEGIN) begin
      goal_hd = tg;
      err_sum = 0;
      if (tg == hd) begin
        move_on    = 1'b0;
        r.done_res = 1'b1;
      end else begin
        move_on  = 1'b1;
        turn_neg = (tg < hd);
      end
    end else if (move_on) begin
      going = turn_neg ? (hd > goal_hd) : (hd < goal_hd);
      if (!going) begin
        move_on    = 1'b0;
        r.done_res = 1'b1;
      end else begin
        errv = turn_neg ? hd - goal_hd : goal_hd - hd;
        p    = (kp_q8 * errv) >> 8;
        itg  = 0;
        // Large proportional term: drop the accumulated error
        if (p > gate_lvl) begin
          err_sum = 0;
        end else begin
          err_sum = err_sum + errv;
          if (err_sum > SUM_MAX) err_sum = SUM_MAX;
          itg = (ki_q8 * (err_sum + bias_val)) >> 8;
          if (itg > ilim) itg = ilim;
        end
        pw = p + itg;
        if (pw > olim) pw = olim;
        pw8 = pw[PWR_W-1:0];
        r.left_power  = turn_neg ? -pw8 : pw8;
        r.right_power = turn_neg ? pw8 : -pw8;
      end
    end
    return r;
  endfunction

  function automatic void add_row(input logic act, input int hd, input int tg,
                                  input bit known, input int lp, input int rp,
                                  input bit dn);
    dir_row_t row;
    row.item.action         = act;
    row.item.heading        = hd[15:0];
    row.item.target         = tg[15:0];
    row.known               = known;
    row.result.left_power   = lp[7:0];
    row.result.right_power  = rp[7:0];
    row.result.done_res     = dn;
    dir_rows.push_back(row);
  endfunction

  // Hold the transfer until accepted; log the expectation at acceptance
  task automatic send_item(input ptc_in_t it, input bit known, input ptc_out_t result);
    ptc_out_t pred;
    bit       stalled;
    if (gappy && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      stalled = in_stall;
      if (!stalled) begin
        pred = predict_turn(it);
        expected_turns.push_back(known ? result : pred);
        items_sent++;
      end
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic drive(input logic act, input int hd, input int tg);
    ptc_in_t it;
    it.action  = act;
    it.heading = hd[15:0];
    it.target  = tg[15:0];
    send_item(it, 1'b0, '0);
  endtask

  // Drop valid and wait until every expected result has been seen
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_turns.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN:  kp_q8    = val[GAIN_W-1:0];
      REG_INTEG_GAIN: ki_q8    = val[GAIN_W-1:0];
      REG_GATE:       gate_lvl = val[7:0];
      REG_BIAS:       bias_val = val[9:0];
      REG_INTEG_LIM:  ilim     = val[LIM_W-1:0];
      REG_OUT_LIM:    olim     = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int kp, input int ki, input int gt,
                            input int bs, input int il, input int ol);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_GATE, gt);
    write_reg(REG_BIAS, bs);
    write_reg(REG_INTEG_LIM, il);
    write_reg(REG_OUT_LIM, ol);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One move: begin, then samples that close in on the goal with some noise
  task automatic run_move();
    int hd;
    int tg;
    int cur;
    int span;
    int mag;
    int n;
    hd = $signed(16'($urandom));
    case ($urandom_range(0, 5))
      0:       tg = $signed(16'($urandom));
      1:       tg = hd;
      default: tg = hd + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 300));
    endcase
    tg    = clamp16(tg);
    gappy = ($urandom_range(0, 2) != 0);
    drive(ACT_BEGIN, hd, tg);
    cur = hd;
    n   = $urandom_range(1, 40);
    for (int k = 0; k < n; k++) begin
      // Occasionally abandon the move; the next begin replaces it
      if ($urandom_range(0, 24) == 0) break;
      if ($urandom_range(0, 15) == 0) begin
        cur = $signed(16'($urandom));
      end else begin
        span = tg - cur;
        mag  = $urandom_range(0, (span < 0 ? -span : span) / 3 + 2);
        if ($urandom_range(0, 9) == 0) mag = -mag;
        cur = clamp16(cur + (span < 0 ? -mag : mag));
      end
      drive(ACT_SAMPLE, cur, $urandom);
      if (!move_on) begin
        if ($urandom_range(0, 3) == 0) drive(ACT_SAMPLE, $urandom, $urandom);
        break;
      end
    end
  endtask

  // Far goal with zero proportional gain: the sum climbs to just below its
  // ceiling, then one more small error shows whether it clamps there or wraps
  task automatic saturate_sum();
    drive(ACT_BEGIN, -32768, 32767);
    repeat (SAT_RUN) drive(ACT_SAMPLE, -32768, $urandom);
    drive(ACT_SAMPLE, 32767 - 256, $urandom);
    repeat (20) drive(ACT_SAMPLE, -32768, $urandom);
  endtask

  // Result check: compare against the oldest expectation
  initial begin
    ptc_out_t seen;
    ptc_out_t want;
    bit       fire;
    forever begin
      @(negedge clk);
      fire = rst_n && out_valid && !out_stall;
      seen = out_data;
      @(posedge clk);
      if (fire) begin
        if (expected_turns.size() == 0) begin
          $display("%0t: result with nothing expected: left %0d right %0d done %0b",
                   $time, seen.left_power, seen.right_power, seen.done_res);
          mismatches++;
        end else begin
          want = expected_turns.pop_front();
          if (seen.left_power !== want.left_power) begin
            $display("%0t: left_power expected %0d got %0d",
                     $time, want.left_power, seen.left_power);
            mismatches++;
          end
          if (seen.right_power !== want.right_power) begin
            $display("%0t: right_power expected %0d got %0d",
                     $time, want.right_power, seen.right_power);
            mismatches++;
          end
          if (seen.done_res !== want.done_res) begin
            $display("%0t: done_res expected %0b got %0b",
                     $time, want.done_res, seen.done_res);
            mismatches++;
          end
        end
      end
    end
  end

  // Result-side stall: short bursts, calm stretches, none at the end
  initial begin
    int pick;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      pick = $urandom_range(0, 15);
      if (!quiet && pick < 2) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (pick == 2) begin
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[pi_turn_controller_gated_integral] ERROR");
      $finish;
    end
  end

  initial begin
    int start;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    kp_q8     = RST_PROP_GAIN;
    ki_q8     = RST_INTEG_GAIN;
    gate_lvl  = RST_GATE;
    bias_val  = RST_BIAS;
    ilim      = RST_INTEG_LIM;
    olim      = RST_OUT_LIM;
    move_on   = 1'b0;
    turn_neg  = 1'b0;
    goal_hd   = 0;
    err_sum   = 0;

    // Directed table at reset settings
    add_row(ACT_SAMPLE, 32767, -32768, 1, 0, 0, 0);   // sample while idle
    add_row(ACT_BEGIN, 5, 5, 1, 0, 0, 1);             // already on target
    add_row(ACT_BEGIN, -32768, 32767, 1, 0, 0, 0);    // widest positive turn
    add_row(ACT_SAMPLE, -32768, -1, 1, 84, -84, 0);   // full error, clamped
    add_row(ACT_SAMPLE, 32700, 0, 0, 0, 0, 0);
    add_row(ACT_SAMPLE, 32760, 0, 0, 0, 0, 0);
    add_row(ACT_SAMPLE, 32766, 0, 0, 0, 0, 0);
    add_row(ACT_SAMPLE, 32767, 0, 1, 0, 0, 1);        // goal reached
    add_row(ACT_SAMPLE, 0, 0, 1, 0, 0, 0);            // idle again
    add_row(ACT_BEGIN, 32767, -32768, 1, 0, 0, 0);    // widest negative turn
    add_row(ACT_SAMPLE, 32767, 32767, 1, -84, 84, 0);
    add_row(ACT_SAMPLE, -32700, 0, 0, 0, 0, 0);
    add_row(ACT_SAMPLE, -32768, 0, 1, 0, 0, 1);
    add_row(ACT_BEGIN, 100, 200, 1, 0, 0, 0);
    add_row(ACT_SAMPLE, 150, -1, 0, 0, 0, 0);         // above gate
    add_row(ACT_SAMPLE, 180, 0, 0, 0, 0, 0);          // integral path
    add_row(ACT_SAMPLE, 300, 0, 1, 0, 0, 1);          // goal crossed
    add_row(ACT_BEGIN, 0, 1000, 1, 0, 0, 0);
    add_row(ACT_SAMPLE, 990, 0, 0, 0, 0, 0);
    add_row(ACT_BEGIN, 1000, 0, 1, 0, 0, 0);          // restart mid-move
    add_row(ACT_SAMPLE, 990, 0, 0, 0, 0, 0);
    add_row(ACT_SAMPLE, 995, 0, 0, 0, 0, 0);
    add_row(ACT_BEGIN, -1, -1, 1, 0, 0, 1);
    add_row(ACT_SAMPLE, -5, -1, 1, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gappy = 1'b1;
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].result);

    // Register settings, extremes first, then random, then defaults
    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0: set_config(1023, 1023, 255, 1023, 127, 127);
        1: set_config(0, 0, 0, 0, 0, 0);
        2: set_config(0, 1, 0, 0, 127, 127);
        5: set_config($urandom_range(0, 300), $urandom_range(0, 1023),
                      $urandom_range(0, 255), $urandom_range(0, 1023),
                      $urandom_range(0, 127), $urandom_range(0, 127));
        6: set_config(RST_PROP_GAIN, RST_INTEG_GAIN, RST_GATE,
                      RST_BIAS, RST_INTEG_LIM, RST_OUT_LIM);
        default: set_config($urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1023));
      endcase
      if (ph == 2) saturate_sum();
      if (ph == 6) quiet = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) run_move();
    end

    settle();
    if (mismatches == 0) begin
      $display("[pi_turn_controller_gated_integral] OK");
    end else begin
      $display("[pi_turn_controller_gated_integral] ERROR");
    end
    $finish;
  end

endmodule
